FILE: hw/rtl/qte_pkg.sv
`default_nettype none
package qte_pkg;

  // field widths
  localparam int QW      = 16;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;
  localparam int YAW_W   = 16;

  // internal datapath widths
  localparam int PROD_W = 32;   // one 16x16 product
  localparam int VEC_W  = 34;   // doubled product sums
  localparam int SP_W   = 30;   // clamped pitch sine, +-2^28
  localparam int RAD_W  = 58;   // 2^56 - sp^2
  localparam int ROOT_W = 30;   // square root of the radicand
  localparam int SQ_STAGES = ROOT_W / 2;
  localparam int CW     = 38;   // cordic x / y width
  localparam int ANG_W  = 26;   // angle, 16 fraction bits of a degree
  localparam int SUM_W  = ANG_W + 1;

  localparam int ATAN_LEN = 24;

  localparam logic signed [VEC_W-1:0] ONE_Q28 = VEC_W'(64'sd268435456);
  localparam logic signed [ANG_W-1:0] DEG90   = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] DEG180  = ANG_W'(180 * 65536);

  localparam logic signed [SUM_W-1:0] ROLL_LIM  = SUM_W'(23040);
  localparam logic signed [SUM_W-1:0] PITCH_LIM = SUM_W'(11520);

  // vectors that travel beside the square root
  typedef struct packed {
    logic signed [VEC_W-1:0] roll_y;
    logic signed [VEC_W-1:0] roll_x;
    logic signed [VEC_W-1:0] yaw_y;
    logic signed [VEC_W-1:0] yaw_x;
    logic signed [SP_W-1:0]  sp;
  } vecs_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded
  function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:  a = ANG_W'(2949120);
      1:  a = ANG_W'(1740967);
      2:  a = ANG_W'(919879);
      3:  a = ANG_W'(466945);
      4:  a = ANG_W'(234379);
      5:  a = ANG_W'(117304);
      6:  a = ANG_W'(58666);
      7:  a = ANG_W'(29335);
      8:  a = ANG_W'(14668);
      9:  a = ANG_W'(7334);
      10: a = ANG_W'(3667);
      11: a = ANG_W'(1833);
      12: a = ANG_W'(917);
      13: a = ANG_W'(458);
      14: a = ANG_W'(229);
      15: a = ANG_W'(115);
      16: a = ANG_W'(57);
      17: a = ANG_W'(29);
      18: a = ANG_W'(14);
      19: a = ANG_W'(7);
      20: a = ANG_W'(4);
      21: a = ANG_W'(2);
      22: a = ANG_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/qte_if.sv
`default_nettype none
interface qte_in_if import qte_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  logic signed [QW-1:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_out_if import qte_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ROLL_W-1:0]  roll_deg;
  logic signed [PITCH_W-1:0] pitch_deg;
  logic signed [YAW_W-1:0]   yaw_deg;
  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/qte_front.sv
`default_nettype none
module qte_front import qte_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [QW-1:0] qx,
  input  wire logic signed [QW-1:0] qy,
  input  wire logic signed [QW-1:0] qz,
  input  wire logic signed [QW-1:0] qw,
  output logic                      out_valid,
  output logic [RAD_W-1:0]          rad,
  output vecs_t                     vecs
);

  localparam int NPROD = 9;
  localparam logic [2*SP_W-1:0] ONE_Q56 = (2*SP_W)'(1) << 56;

  function automatic logic signed [VEC_W-1:0] ext(input logic signed [PROD_W-1:0] v);
    return {{(VEC_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  // product order: wx yz xx yy wz xy zz wy zx
  logic signed [PROD_W-1:0] p_r [NPROD];
  logic                     v1_r, v2_r, v3_r;
  vecs_t                    vecs2_r, vecs_nxt, vecs3_r;
  logic [RAD_W-1:0]         rad3_r;
  logic signed [VEC_W-1:0]  sp_full;
  logic signed [2*SP_W-1:0] sq;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= qw * qx;
      p_r[1] <= qy * qz;
      p_r[2] <= qx * qx;
      p_r[3] <= qy * qy;
      p_r[4] <= qw * qz;
      p_r[5] <= qx * qy;
      p_r[6] <= qz * qz;
      p_r[7] <= qw * qy;
      p_r[8] <= qz * qx;
    end
  end

  // stage 2: doubled sums and the pitch sine clamp
  always_comb begin
    vecs_nxt.roll_y = (ext(p_r[0]) + ext(p_r[1])) <<< 1;
    vecs_nxt.roll_x = ONE_Q28 - ((ext(p_r[2]) + ext(p_r[3])) <<< 1);
    vecs_nxt.yaw_y  = (ext(p_r[4]) + ext(p_r[5])) <<< 1;
    vecs_nxt.yaw_x  = ONE_Q28 - ((ext(p_r[3]) + ext(p_r[6])) <<< 1);
    sp_full = (ext(p_r[7]) - ext(p_r[8])) <<< 1;
    if (sp_full > ONE_Q28) begin
      vecs_nxt.sp = SP_W'(ONE_Q28);
    end else if (sp_full < -ONE_Q28) begin
      vecs_nxt.sp = SP_W'(-ONE_Q28);
    end else begin
      vecs_nxt.sp = SP_W'(sp_full);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vecs2_r <= vecs_nxt;
    end
  end

  // stage 3: radicand 2^56 - sp^2
  assign sq = vecs2_r.sp * vecs2_r.sp;

  always_ff @(posedge clk) begin
    if (en) begin
      rad3_r  <= RAD_W'(ONE_Q56 - sq);
      vecs3_r <= vecs2_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign rad       = rad3_r;
  assign vecs      = vecs3_r;

endmodule
`default_nettype wire

FILE: hw/rtl/qte_sqrt.sv
`default_nettype none
module qte_sqrt import qte_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [RAD_W-1:0] rad,
  input  vecs_t                 in_vecs,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output vecs_t                 out_vecs
);

  localparam int TW = 2 * ROOT_W + 2;

  // stage registers, two root bits resolved per stage
  logic [RAD_W-1:0]  rem_r  [SQ_STAGES];
  logic [ROOT_W-1:0] root_r [SQ_STAGES];
  vecs_t             vecs_r [SQ_STAGES];
  logic              v_r    [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    localparam int K0 = ROOT_W - 1 - 2 * s;
    localparam int K1 = K0 - 1;

    logic [RAD_W-1:0]  rem_in, rem_mid, rem_nxt;
    logic [ROOT_W-1:0] root_in, root_mid, root_nxt;
    logic [TW-1:0]     t0, t1;

    if (s == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_rest
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    // restoring steps for bits K0 and K1
    always_comb begin
      t0 = (TW'(root_in) << (K0 + 1)) | (TW'(1) << (2 * K0));
      if (TW'(rem_in) >= t0) begin
        rem_mid  = RAD_W'(TW'(rem_in) - t0);
        root_mid = root_in | (ROOT_W'(1) << K0);
      end else begin
        rem_mid  = rem_in;
        root_mid = root_in;
      end
      t1 = (TW'(root_mid) << (K1 + 1)) | (TW'(1) << (2 * K1));
      if (TW'(rem_mid) >= t1) begin
        rem_nxt  = RAD_W'(TW'(rem_mid) - t1);
        root_nxt = root_mid | (ROOT_W'(1) << K1);
      end else begin
        rem_nxt  = rem_mid;
        root_nxt = root_mid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        vecs_r[s] <= (s == 0) ? in_vecs : vecs_r[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= (s == 0) ? in_valid : v_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign out_valid = v_r[SQ_STAGES-1];
  assign root      = root_r[SQ_STAGES-1];
  assign out_vecs  = vecs_r[SQ_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/qte_cordic.sv
`default_nettype none
module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [CW-1:0] y_in,
  input  wire logic signed [CW-1:0] x_in,
  output logic                      out_valid,
  output logic signed [ANG_W-1:0]   angle
);

  logic signed [CW-1:0]    x_r [STEPS+1];
  logic signed [CW-1:0]    y_r [STEPS+1];
  logic signed [ANG_W-1:0] z_r [STEPS+1];
  logic                    done_r [STEPS+1];
  logic                    v_r [STEPS+1];

  // pre stage: axis cases and fold of the left half plane
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in == '0) begin
        x_r[0]    <= x_in;
        y_r[0]    <= y_in;
        z_r[0]    <= (x_in < 0) ? DEG180 : '0;
        done_r[0] <= 1'b1;
      end else if (x_in == '0) begin
        x_r[0]    <= x_in;
        y_r[0]    <= y_in;
        z_r[0]    <= (y_in > 0) ? DEG90 : -DEG90;
        done_r[0] <= 1'b1;
      end else if (x_in < 0) begin
        x_r[0]    <= -x_in;
        y_r[0]    <= -y_in;
        z_r[0]    <= (y_in >= 0) ? DEG180 : -DEG180;
        done_r[0] <= 1'b0;
      end else begin
        x_r[0]    <= x_in;
        y_r[0]    <= y_in;
        z_r[0]    <= '0;
        done_r[0] <= 1'b0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        done_r[i+1] <= done_r[i];
        if (done_r[i]) begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end else if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + atan_q16(i);
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - atan_q16(i);
        end
      end
    end
  end

  // valid bits
  for (genvar i = 0; i <= STEPS; i++) begin : g_valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign angle     = z_r[STEPS];

endmodule
`default_nettype wire

FILE: hw/rtl/quaternion_to_euler_degrees_core.sv
// Quaternion to roll / pitch / yaw converter.
// in_chan takes one quaternion word (x, y, z, w; signed, 16384 = 1.0) at
// each edge where valid and ready are both high. out_chan gives roll, pitch
// and yaw in 1/128 degree, one result word per input word, in order.
// Throughput: one word per cycle, sustained while out ready stays high.
// Pipeline from acceptance to out valid: 3 product/sum stages, 15
// square-root stages (two root bits each), CORDIC_STEPS + 1 CORDIC stages
// (one micro-rotation each), and the rounding output register.
// Roll and yaw travel beside the square root and then run through their
// own CORDIC pipelines in parallel with pitch.
// The whole pipeline advances together; when out ready is low with a word
// waiting, every stage holds and in ready drops, so nothing is lost or
// repeated. Bubbles advance freely while the output register is empty.
// Reset clears all valid bits; no word is in flight afterwards.
`default_nettype none
module quaternion_to_euler_degrees_core import qte_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qte_in_if.sink     in_chan,
  qte_out_if.source  out_chan
);

  logic                      en;
  logic                      out_valid_r;
  logic signed [ROLL_W-1:0]  roll_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic signed [YAW_W-1:0]   yaw_r;

  logic                    f_valid, s_valid;
  logic [RAD_W-1:0]        rad;
  vecs_t                   f_vecs, s_vecs;
  logic [ROOT_W-1:0]       root;
  logic                    cr_valid, cp_valid, cy_valid;
  logic signed [ANG_W-1:0] roll_a, pitch_a, yaw_a;

  // global advance
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  qte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_chan.valid),
    .qx        (in_chan.quat_x),
    .qy        (in_chan.quat_y),
    .qz        (in_chan.quat_z),
    .qw        (in_chan.quat_w),
    .out_valid (f_valid),
    .rad       (rad),
    .vecs      (f_vecs)
  );

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .rad       (rad),
    .in_vecs   (f_vecs),
    .out_valid (s_valid),
    .root      (root),
    .out_vecs  (s_vecs)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .y_in      (CW'(s_vecs.roll_y)),
    .x_in      (CW'(s_vecs.roll_x)),
    .out_valid (cr_valid),
    .angle     (roll_a)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .y_in      (CW'(s_vecs.sp)),
    .x_in      ($signed({{(CW-ROOT_W){1'b0}}, root})),
    .out_valid (cp_valid),
    .angle     (pitch_a)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .y_in      (CW'(s_vecs.yaw_y)),
    .x_in      (CW'(s_vecs.yaw_x)),
    .out_valid (cy_valid),
    .angle     (yaw_a)
  );

  // round half up to 1/128 degree and saturate
  function automatic logic signed [SUM_W-1:0] round_sat(
    input logic signed [ANG_W-1:0] a,
    input logic signed [SUM_W-1:0] lim
  );
    logic signed [SUM_W-1:0] r;
    r = SUM_W'(a) + SUM_W'(256);
    r = r >>> 9;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= ROLL_W'(round_sat(roll_a, ROLL_LIM));
      pitch_r <= PITCH_W'(round_sat(pitch_a, PITCH_LIM));
      yaw_r   <= YAW_W'(round_sat(yaw_a, ROLL_LIM));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cr_valid && cp_valid && cy_valid;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.roll_deg  = roll_r;
  assign out_chan.pitch_deg = pitch_r;
  assign out_chan.yaw_deg   = yaw_r;

endmodule
`default_nettype wire

FILE: hw/rtl/qte_checker.sv
`default_nettype none
module qte_checker import qte_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [ROLL_W-1:0]  roll_deg,
  input wire logic signed [PITCH_W-1:0] pitch_deg,
  input wire logic signed [YAW_W-1:0]   yaw_deg
);

  // nothing leaves the block right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid high after reset");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in ready low with empty output");

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // angle ranges
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pitch_deg <= 15'sd11520) && (pitch_deg >= -15'sd11520))
    else $error("pitch out of range");

  a_roll_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (roll_deg <= 16'sd23040) && (roll_deg >= -16'sd23040) &&
                  (yaw_deg <= 16'sd23040) && (yaw_deg >= -16'sd23040))
    else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_degrees_core qte_checker u_qte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .roll_deg  (out_chan.roll_deg),
  .pitch_deg (out_chan.pitch_deg),
  .yaw_deg   (out_chan.yaw_deg)
);
`default_nettype wire
